// ===== src/assert_macros.svh =====
// Assertion macros for the checker module of the permutation ranking block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/prru_pkg.sv =====
// Shared types and constants for the nine-element permutation rank/unrank block.
// No dependencies; used by every module of the block.
package prru_pkg;

  localparam int unsigned NPOS    = 9;
  localparam int unsigned ELEM_W  = 4;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned RANK_W  = 19;
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned PROD_W  = RANK_W + RECIP_W;
  localparam int unsigned PERM_W  = NPOS * ELEM_W;
  localparam int unsigned TDATA_W = ((RANK_W + PERM_W + 7) / 8) * 8;

  typedef logic [3:0]                    pos_t;
  typedef logic [ELEM_W-1:0]             elem_t;
  typedef logic [NPOS-1:0][ELEM_W-1:0]   perm_t;

  // Weight of each position: (8 - i)!
  localparam logic [RANK_W-1:0] FACT_W [NPOS] = '{
    19'd40320, 19'd5040, 19'd720, 19'd120, 19'd24, 19'd6, 19'd2, 19'd1, 19'd1
  };

  // floor(t / FACT_W[i]) == (t * RECIP[i]) >> RSHIFT[i] for every 19-bit t
  localparam int unsigned RSHIFT [NPOS] = '{35, 32, 29, 26, 24, 22, 20, 19, 19};

  localparam logic [RECIP_W-1:0] RECIP [NPOS] = '{
    20'(((64'd1 << 35) + 64'd40319) / 64'd40320),
    20'(((64'd1 << 32) + 64'd5039) / 64'd5040),
    20'(((64'd1 << 29) + 64'd719) / 64'd720),
    20'(((64'd1 << 26) + 64'd119) / 64'd120),
    20'(((64'd1 << 24) + 64'd23) / 64'd24),
    20'(((64'd1 << 22) + 64'd5) / 64'd6),
    20'(((64'd1 << 20) + 64'd1) / 64'd2),
    20'(64'd1 << 19),
    20'(64'd1 << 19)
  };

  // First pipeline stage: per-lane inversion counts and rank quotients
  typedef struct packed {
    logic                              func;
    logic [NPOS-1:0][CNT_W-1:0]        count;
    logic [NPOS-1:0][RANK_W-1:0]       quot;
  } stage_a_t;

  // Second pipeline stage: weighted terms and mixed-radix digits
  typedef struct packed {
    logic                              func;
    logic [NPOS-1:0][RANK_W-1:0]       term;
    logic [NPOS-1:0][ELEM_W-1:0]       digit;
  } stage_b_t;

endpackage

// ===== src/permutation_rank_unrank.sv =====
// Throughput one item per cycle while the output is not stalled.
// Stages: nine lanes (compare/count and reciprocal divide), digit and weight prep,
// then merge (rank sum, permutation fix-up) into the output register.
// Each stage holds only while the stage after it is full and stalled.
// Reset (rst_ni low, asynchronous) empties the pipeline; payload registers are not cleared.
module permutation_rank_unrank import prru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // perm_in_0 .. perm_in_8 (4 bits each), rank_in (19 bits), one zero pad bit
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  // func: 0 = rank, 1 = unrank
  input  logic               s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // rank_out (19 bits), perm_out_0 .. perm_out_8 (4 bits each), one zero pad bit
  output logic [TDATA_W-1:0] m_axis_tdata_o
);

  perm_t             perm_in;
  logic [RANK_W-1:0] rank_in;
  logic [CNT_W-1:0]  lane_cnt  [NPOS];
  logic [RANK_W-1:0] lane_quot [NPOS];

  stage_a_t          stage_a_d, stage_a_q;
  stage_b_t          stage_b_d, stage_b_q;
  logic [RANK_W-1:0] rank_d, rank_q;
  perm_t             perm_d, perm_q;
  logic              va_q, vb_q, vc_q;
  logic              ready_a, ready_b, ready_c;

  assign perm_in = s_axis_tdata_i[PERM_W-1:0];
  assign rank_in = s_axis_tdata_i[PERM_W +: RANK_W];

  for (genvar g = 0; g < NPOS; g++) begin : g_lane
    prru_lane u_lane (
      .lane_idx_i (pos_t'(g)),
      .perm_i     (perm_in),
      .rank_i     (rank_in),
      .count_o    (lane_cnt[g]),
      .quot_o     (lane_quot[g])
    );
  end

  always_comb begin
    stage_a_d.func = s_axis_tuser_i;
    for (int i = 0; i < NPOS; i++) begin
      stage_a_d.count[i] = lane_cnt[i];
      stage_a_d.quot[i]  = lane_quot[i];
    end
  end

  prru_prep u_prep (
    .a_i (stage_a_q),
    .b_o (stage_b_d)
  );

  prru_merge u_merge (
    .b_i    (stage_b_q),
    .rank_o (rank_d),
    .perm_o (perm_d)
  );

  // a stage may load when it is empty or its contents move on this cycle
  assign ready_c = !vc_q || m_axis_tready_i;
  assign ready_b = !vb_q || ready_c;
  assign ready_a = !va_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= s_axis_tvalid_i;
      if (ready_b) vb_q <= va_q;
      if (ready_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && s_axis_tvalid_i) stage_a_q <= stage_a_d;
    if (ready_b && va_q)            stage_b_q <= stage_b_d;
    if (ready_c && vb_q) begin
      rank_q <= rank_d;
      perm_q <= perm_d;
    end
  end

  assign s_axis_tready_o = ready_a;
  assign m_axis_tvalid_o = vc_q;
  assign m_axis_tdata_o  = TDATA_W'({perm_q, rank_q});

endmodule

// ===== src/prru_lane.sv =====
// One position lane: counts later smaller elements and divides the rank by the
// position's factorial weight. Depends on prru_pkg.
module prru_lane import prru_pkg::*; (
  input  pos_t              lane_idx_i,
  input  perm_t             perm_i,
  input  logic [RANK_W-1:0] rank_i,
  output logic [CNT_W-1:0]  count_o,
  output logic [RANK_W-1:0] quot_o
);

  elem_t             pivot;
  logic [PROD_W-1:0] prod;

  always_comb begin
    pivot   = perm_i[lane_idx_i];
    count_o = '0;
    for (int j = 0; j < NPOS; j++) begin
      if ((pos_t'(j) > lane_idx_i) && (perm_i[j] < pivot)) begin
        count_o = count_o + CNT_W'(1);
      end
    end
  end

  // reciprocal multiply stands in for the constant divide
  assign prod   = PROD_W'(rank_i) * PROD_W'(RECIP[lane_idx_i]);
  assign quot_o = RANK_W'(prod >> RSHIFT[lane_idx_i]);

endmodule

// ===== src/prru_prep.sv =====
// Weights the inversion counts and extracts the mixed-radix digits from the
// per-lane quotients. Depends on prru_pkg.
module prru_prep import prru_pkg::*; (
  input  stage_a_t a_i,
  output stage_b_t b_o
);

  logic [RANK_W-1:0] diff [NPOS];
  elem_t             q0;

  always_comb begin
    b_o.func = a_i.func;
    q0       = a_i.quot[0][ELEM_W-1:0];
    diff[0]  = '0;
    for (int i = 0; i < NPOS; i++) begin
      b_o.term[i] = RANK_W'(RANK_W'(a_i.count[i]) * FACT_W[i]);
    end
    // leading digit: quotient by 8! folded into radix nine
    b_o.digit[0] = (q0 >= ELEM_W'(NPOS)) ? q0 - ELEM_W'(NPOS) : q0;
    for (int i = 1; i < NPOS; i++) begin
      diff[i]      = a_i.quot[i] - RANK_W'(a_i.quot[i-1] * RANK_W'(NPOS - i));
      b_o.digit[i] = diff[i][ELEM_W-1:0];
    end
  end

endmodule

// ===== src/prru_merge.sv =====
// Merges lane results: sums the weighted terms into the rank and applies the
// increment fix-up that turns digits into the permutation. Depends on prru_pkg.
module prru_merge import prru_pkg::*; (
  input  stage_b_t          b_i,
  output logic [RANK_W-1:0] rank_o,
  output perm_t             perm_o
);

  logic [RANK_W-1:0] acc;
  elem_t             fix [NPOS];

  always_comb begin
    acc = '0;
    for (int i = 0; i < NPOS; i++) begin
      acc = acc + b_i.term[i];
    end
    fix[0] = b_i.digit[0];
    for (int i = 1; i < NPOS; i++) begin
      fix[i] = b_i.digit[i];
      // bump once per earlier digit not above the running value, nearest first
      for (int j = i - 1; j >= 0; j--) begin
        if (b_i.digit[j] <= fix[i]) begin
          fix[i] = fix[i] + ELEM_W'(1);
        end
      end
    end
    rank_o = b_i.func ? '0 : acc;
    for (int i = 0; i < NPOS; i++) begin
      perm_o[i] = b_i.func ? fix[i] : '0;
    end
  end

endmodule

// ===== src/prru_checker.sv =====
// Port-level checker for permutation_rank_unrank, attached by bind.
// Depends on prru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prru_checker import prru_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o
);

  logic              out_valid;
  logic              out_stall;
  logic [RANK_W-1:0] out_rank;
  logic [PERM_W-1:0] out_perm;

  assign out_valid = m_axis_tvalid_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_rank  = m_axis_tdata_o[RANK_W-1:0];
  assign out_perm  = m_axis_tdata_o[RANK_W +: PERM_W];

  // a stalled result stays put
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid && $stable(m_axis_tdata_o))

  // only one of rank and permutation fields carries data
  `ASSERT_IMPL(a_mode_excl, clk_i, rst_ni, out_valid, (out_rank == '0) || (out_perm == '0))

  // the rank sum never leaves 0 .. 9! - 1
  `ASSERT_IMPL(a_rank_range, clk_i, rst_ni, out_valid, out_rank < RANK_W'(362880))

  // the leading element, taken from the folded leading digit, never exceeds eight
  `ASSERT_IMPL(a_perm_range, clk_i, rst_ni, out_valid, out_perm[ELEM_W-1:0] <= ELEM_W'(NPOS - 1))

endmodule

bind permutation_rank_unrank prru_checker u_prru_checker (.*);
